// ===== rtl/core/phgb_pkg.sv =====
// -----------------------------------------------------------------------------
// Polar height grid package
// Shared types, constants and the arctangent table of the polar height grid.
// -----------------------------------------------------------------------------
`default_nettype none

package phgb_pkg;

  // Coordinate and grid geometry.
  localparam int CW          = 20;
  localparam int MAX_RINGS   = 32;
  localparam int MAX_SECTORS = 64;
  localparam int RING_W      = $clog2(MAX_RINGS);
  localparam int SECT_W      = $clog2(MAX_SECTORS);
  localparam int IDX_W       = RING_W + SECT_W;
  localparam int CELLS       = MAX_RINGS * MAX_SECTORS;
  localparam int RCNT_W      = 6;
  localparam int SCNT_W      = 7;
  localparam int CSTEPS      = 20;
  localparam int ZW          = 34;

  localparam logic signed [CW-1:0] HEIGHT_MAX = {1'b0, {(CW-1){1'b1}}};

  // Input action codes.
  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [1:0] ACT_NOP   = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_RING_COUNT   = 3'd0;
  localparam logic [2:0] REG_SECTOR_COUNT = 3'd1;
  localparam logic [2:0] REG_RANGE_MIN    = 3'd2;
  localparam logic [2:0] REG_RANGE_MAX    = 3'd3;
  localparam logic [2:0] REG_FIRST_AXIS   = 3'd4;
  localparam logic [2:0] REG_SECOND_AXIS  = 3'd5;
  localparam logic [2:0] REG_HEIGHT_AXIS  = 3'd6;
  localparam logic [2:0] REG_HEIGHT_FLIP  = 3'd7;

  // Axis codes.
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Operation carried from the front end to the cell store.
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef struct packed {
    op_e                   op;
    logic [IDX_W-1:0]      idx;
    logic signed [CW-1:0]  height;
  } item_t;

  typedef struct packed {
    logic [RCNT_W-1:0] ring_count;
    logic [SCNT_W-1:0] sector_count;
    logic [CW-1:0]     range_min;
    logic [CW-1:0]     range_max;
    logic [1:0]        first_axis;
    logic [1:0]        second_axis;
    logic [1:0]        height_axis;
    logic              height_flip;
  } cfg_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/phgb_front.sv =====
// -----------------------------------------------------------------------------
// Polar height grid front end
// Accepts one command, checks the planar range, searches the ring, runs the
// angle CORDIC and hands a classified operation to the queue.
// -----------------------------------------------------------------------------
`default_nettype none

module phgb_front
  import phgb_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cfg_t                 cfg_i,
  input  wire logic                 start_i,
  input  wire logic [1:0]           action_i,
  input  wire logic signed [CW-1:0] coord_x_i,
  input  wire logic signed [CW-1:0] coord_y_i,
  input  wire logic signed [CW-1:0] coord_z_i,
  input  wire logic [RING_W-1:0]    read_ring_i,
  input  wire logic [SECT_W-1:0]    read_sector_i,
  output logic                      idle_o,
  input  wire logic                 q_full_i,
  output logic                      q_push_o,
  output item_t                     q_item_o
);

  typedef enum logic [9:0] {
    F_IDLE = 10'b0000000001,
    F_SQR  = 10'b0000000010,
    F_CHK  = 10'b0000000100,
    F_LHS0 = 10'b0000001000,
    F_LHS1 = 10'b0000010000,
    F_RSQ  = 10'b0000100000,
    F_RCMP = 10'b0001000000,
    F_CINI = 10'b0010000000,
    F_CORD = 10'b0100000000,
    F_SEC  = 10'b1000000000
  } fstate_e;

  fstate_e state_q, state_d;

  logic signed [CW-1:0]   a_q, b_q;
  item_t                  item_q;
  logic [2*CW-1:0]        aa_q, bb_q, mn2_q, mx2_q;
  logic [2*CW:0]          r2_q;
  logic [RCNT_W-1:0]      rcnt_q;
  logic [SCNT_W-1:0]      scnt_q;
  logic [2*RCNT_W-2:0]    rsq_q;
  logic [2*CW+RCNT_W+4:0] lhs_q;
  logic [31:0]            plo_q;
  logic [RCNT_W-1:0]      k_q;
  logic [RING_W-1:0]      ring_q;
  logic [CW+4:0]          edge_q;
  logic [2*CW+9:0]        sq_q;
  logic signed [ZW-1:0]   cx_q, cy_q, cz_q;
  logic                   base_q;
  logic [4:0]             i_q;
  logic                   push_q;

  // Axis selection and height clamp on the incoming coordinates.
  function automatic logic signed [CW-1:0] pick(input logic [1:0] ax,
                                                input logic signed [CW-1:0] x,
                                                input logic signed [CW-1:0] y,
                                                input logic signed [CW-1:0] z);
    logic signed [CW-1:0] v;
    if (ax == AXIS_Y) v = y;
    else if (ax == AXIS_Z) v = z;
    else v = x;
    return v;
  endfunction

  logic signed [CW-1:0] h_sel;
  logic signed [CW:0]   h_ext;
  logic signed [CW-1:0] h_clamp;

  always_comb begin
    h_sel = pick(cfg_i.height_axis, coord_x_i, coord_y_i, coord_z_i);
    h_ext = cfg_i.height_flip ? -{h_sel[CW-1], h_sel} : {h_sel[CW-1], h_sel};
    if (h_ext > $signed({1'b0, HEIGHT_MAX})) begin
      h_clamp = HEIGHT_MAX;
    end else if (h_ext < -$signed({1'b0, HEIGHT_MAX})) begin
      h_clamp = -HEIGHT_MAX;
    end else begin
      h_clamp = h_ext[CW-1:0];
    end
  end

  // Range window check and ring scale.
  logic [2*CW:0]            r2_sum;
  logic                     keep;
  logic [2*CW+RCNT_W+4:0]   lhs_sum;
  logic [RCNT_W-1:0]        rcnt_c;
  logic [SCNT_W-1:0]        scnt_c;

  always_comb begin
    r2_sum  = {1'b0, aa_q} + {1'b0, bb_q};
    keep    = !((r2_sum < {1'b0, mn2_q}) || (r2_sum > {1'b0, mx2_q}));
    lhs_sum = ({(2*CW+RCNT_W+5)'(r2_q[2*CW:21] * rsq_q)} << 21)
              + (2*CW+RCNT_W+5)'(plo_q);
    if (cfg_i.ring_count == '0) rcnt_c = RCNT_W'(1);
    else if (cfg_i.ring_count > RCNT_W'(MAX_RINGS)) rcnt_c = RCNT_W'(MAX_RINGS);
    else rcnt_c = cfg_i.ring_count;
    if (cfg_i.sector_count == '0) scnt_c = SCNT_W'(1);
    else if (cfg_i.sector_count > SCNT_W'(MAX_SECTORS)) scnt_c = SCNT_W'(MAX_SECTORS);
    else scnt_c = cfg_i.sector_count;
  end

  // One CORDIC vectoring step and the final turn fraction.
  logic signed [ZW-1:0] dx, dy, at;
  logic [31:0]          tfull;
  logic [15:0]          t;
  logic [SCNT_W+15:0]   prod;
  logic [SCNT_W-1:0]    sec7;
  logic [SECT_W-1:0]    sec;

  always_comb begin
    dx    = cy_q >>> i_q;
    dy    = cx_q >>> i_q;
    at    = $signed({2'b00, atan_lut(i_q)});
    tfull = {base_q, 31'b0} + cz_q[31:0];
    t     = tfull[31:16];
    prod  = t * scnt_q;
    sec7  = prod[SCNT_W+15:16];
    if (sec7 > scnt_q - SCNT_W'(1)) sec7 = scnt_q - SCNT_W'(1);
    sec   = sec7[SECT_W-1:0];
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: if (start_i) state_d = (action_i == ACT_ADD) ? F_SQR : F_SEC;
      F_SQR:  state_d = F_CHK;
      F_CHK:  state_d = keep ? F_LHS0 : F_IDLE;
      F_LHS0: state_d = F_LHS1;
      F_LHS1: begin
        state_d = ((cfg_i.range_max == '0) || (rcnt_q == RCNT_W'(1))) ? F_CINI : F_RSQ;
      end
      F_RSQ:  state_d = F_RCMP;
      F_RCMP: begin
        if (({2'b00, sq_q} <= lhs_q) && ((k_q + RCNT_W'(1)) < rcnt_q)) state_d = F_RSQ;
        else state_d = F_CINI;
      end
      F_CINI: state_d = ((b_q == '0) || (a_q == '0)) ? F_SEC : F_CORD;
      F_CORD: if (i_q == 5'(CSTEPS - 1)) state_d = F_SEC;
      F_SEC:  if (!push_q || !q_full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        a_q    <= pick(cfg_i.first_axis, coord_x_i, coord_y_i, coord_z_i);
        b_q    <= pick(cfg_i.second_axis, coord_x_i, coord_y_i, coord_z_i);
        rcnt_q <= rcnt_c;
        scnt_q <= scnt_c;
        item_q.idx    <= {read_ring_i, read_sector_i};
        item_q.height <= h_clamp;
        push_q <= (action_i != ACT_NOP);
        if (action_i == ACT_READ) item_q.op <= OP_READ;
        else if (action_i == ACT_CLEAR) item_q.op <= OP_CLEAR;
        else item_q.op <= OP_ADD;
      end
      F_SQR: begin
        aa_q  <= (2*CW)'(a_q * a_q);
        bb_q  <= (2*CW)'(b_q * b_q);
        mn2_q <= (2*CW)'(cfg_i.range_min * cfg_i.range_min);
        mx2_q <= (2*CW)'(cfg_i.range_max * cfg_i.range_max);
        rsq_q <= (2*RCNT_W-1)'(rcnt_q * rcnt_q);
      end
      F_CHK: r2_q <= r2_sum;
      F_LHS0: plo_q <= 32'(r2_q[20:0] * rsq_q);
      F_LHS1: begin
        lhs_q  <= lhs_sum;
        ring_q <= '0;
        k_q    <= RCNT_W'(1);
        edge_q <= (CW+5)'(cfg_i.range_max);
      end
      F_RSQ: sq_q <= (2*CW+10)'(edge_q * edge_q);
      F_RCMP: begin
        if ({2'b00, sq_q} <= lhs_q) begin
          ring_q <= k_q[RING_W-1:0];
          k_q    <= k_q + RCNT_W'(1);
          edge_q <= edge_q + (CW+5)'(cfg_i.range_max);
        end
      end
      F_CINI: begin
        i_q    <= '0;
        base_q <= 1'b0;
        if (b_q == '0) begin
          cz_q <= a_q[CW-1] ? $signed({2'b00, 16'd32768, 16'd0}) : '0;
        end else if (a_q == '0) begin
          cz_q <= b_q[CW-1] ? $signed({2'b00, 16'd49152, 16'd0})
                            : $signed({2'b00, 16'd16384, 16'd0});
        end else begin
          cz_q   <= '0;
          base_q <= a_q[CW-1];
          cx_q   <= (a_q[CW-1] ? -ZW'(a_q) : ZW'(a_q)) <<< 10;
          cy_q   <= (a_q[CW-1] ? -ZW'(b_q) : ZW'(b_q)) <<< 10;
        end
      end
      F_CORD: begin
        i_q <= i_q + 5'd1;
        if (cy_q > 0) begin
          cx_q <= cx_q + dx;
          cy_q <= cy_q - dy;
          cz_q <= cz_q + at;
        end else begin
          cx_q <= cx_q - dx;
          cy_q <= cy_q + dy;
          cz_q <= cz_q - at;
        end
      end
      F_SEC: begin
        if (item_q.op == OP_ADD && (!push_q || !q_full_i)) begin
          push_q <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Hand-off to the queue.
  always_comb begin
    q_item_o = item_q;
    if (item_q.op == OP_ADD) q_item_o.idx = {ring_q, sec};
    q_push_o = (state_q == F_SEC) && push_q && !q_full_i;
    idle_o   = (state_q == F_IDLE);
  end

endmodule

`default_nettype wire

// ===== rtl/core/phgb_fifo.sv =====
// -----------------------------------------------------------------------------
// Polar height grid operation queue
// Two-entry queue between the front end and the cell store.
// -----------------------------------------------------------------------------
`default_nettype none

module phgb_fifo
  import phgb_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       empty_o,
  output item_t      item_o
);

  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign item_o  = mem_q[rd_q];

endmodule

`default_nettype wire

// ===== rtl/core/phgb_back.sv =====
// -----------------------------------------------------------------------------
// Polar height grid cell store
// Holds the per-cell peaks and the scan floor, executes adds, reads and
// clearing sweeps taken from the queue.
// -----------------------------------------------------------------------------
`default_nettype none

module phgb_back
  import phgb_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     q_empty_i,
  input  wire item_t    q_item_i,
  output logic          q_pop_o,
  output logic          init_o,
  output logic          result_valid_o,
  output logic [CW-1:0] cell_height_o,
  output logic          cell_occupied_o
);

  typedef enum logic [2:0] {
    B_CLR  = 3'b001,
    B_IDLE = 3'b010,
    B_EXE  = 3'b100
  } bstate_e;

  bstate_e              state_q, state_d;
  logic [IDX_W-1:0]     cnt_q;
  logic                 init_q;
  logic signed [CW-1:0] low_q;
  item_t                cur_q;
  logic                 res_v_q, res_o_q;
  logic [CW-1:0]        res_h_q;

  // Cell memory: filled flag over the signed peak.
  logic [CW:0]          mem [CELLS];
  logic [CW:0]          rdata_q;
  logic                 we, re;
  logic [IDX_W-1:0]     waddr;
  logic [CW:0]          wdata;

  logic                 filled;
  logic signed [CW-1:0] peak;

  always_comb begin
    filled  = rdata_q[CW];
    peak    = $signed(rdata_q[CW-1:0]);
    q_pop_o = (state_q == B_IDLE) && !q_empty_i;
    re      = q_pop_o;
    we      = 1'b0;
    waddr   = cur_q.idx;
    wdata   = {1'b1, cur_q.height};
    state_d = state_q;
    unique case (state_q)
      B_CLR: begin
        we    = 1'b1;
        waddr = cnt_q;
        wdata = '0;
        if (cnt_q == '1) state_d = B_IDLE;
      end
      B_IDLE: begin
        if (q_pop_o) state_d = (q_item_i.op == OP_CLEAR) ? B_CLR : B_EXE;
      end
      B_EXE: begin
        we      = (cur_q.op == OP_ADD);
        if (filled && !(cur_q.height > peak)) wdata = {1'b1, peak};
        state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[q_item_i.idx];
  end

  // Control and scan floor.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_CLR;
      cnt_q   <= '0;
      init_q  <= 1'b1;
      low_q   <= HEIGHT_MAX;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      res_v_q <= (state_q == B_EXE) && (cur_q.op == OP_READ);
      if (state_q == B_CLR) begin
        cnt_q <= cnt_q + IDX_W'(1);
        if (cnt_q == '1) init_q <= 1'b0;
      end
      if (q_pop_o && q_item_i.op == OP_CLEAR) begin
        cnt_q <= '0;
        low_q <= HEIGHT_MAX;
      end
      if (state_q == B_EXE && cur_q.op == OP_ADD && cur_q.height < low_q) begin
        low_q <= cur_q.height;
      end
    end
  end

  // Operation and result payload.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) cur_q <= q_item_i;
    if (state_q == B_EXE) begin
      res_o_q <= filled;
      res_h_q <= filled ? CW'(peak - low_q) : '0;
    end
  end

  assign init_o          = init_q;
  assign result_valid_o  = res_v_q;
  assign cell_height_o   = res_h_q;
  assign cell_occupied_o = res_o_q;

endmodule

`default_nettype wire

// ===== rtl/core/polar_height_grid_binning.sv =====
// -----------------------------------------------------------------------------
// Polar height grid binning
// Bins lidar points into ring/sector cells, keeping per-cell peak heights and
// the scan floor, and reports a cell's height above that floor on request.
// -----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. A kept add runs the
// front end through squaring, the range check, the ring scale, a squaring and
// compare per ring boundary (one more than the ring found, capped at the rings
// in use less one, so at most 31 comparisons, and none with a single ring or a
// zero range scale), the 20 CORDIC iterations that a point on an axis skips,
// and the hand-off. A dropped point stops after the range check; reads, clears
// and unused commands go straight to the hand-off, which stretches while the
// two-entry queue is full. The cell store reads and then executes each add or
// read and sweeps all 2048 cell flags on a clear, so the queue lets the front
// end run ahead. After reset the same sweep runs with busy high. A read returns
// its result in the cycle after the store executes it, flagged for one cycle by
// result_valid_o; the receiver cannot stall it.
`default_nettype none

module polar_height_grid_binning
  import phgb_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           action_i,
  input  wire logic signed [CW-1:0] coord_x_i,
  input  wire logic signed [CW-1:0] coord_y_i,
  input  wire logic signed [CW-1:0] coord_z_i,
  input  wire logic [RING_W-1:0]    read_ring_i,
  input  wire logic [SECT_W-1:0]    read_sector_i,
  output logic                      result_valid_o,
  output logic [CW-1:0]             cell_height_o,
  output logic                      cell_occupied_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [2:0]           cfg_index_i,
  input  wire logic [CW-1:0]        cfg_data_i
);

  cfg_t  cfg_q;
  logic  front_idle, back_init;
  logic  q_push, q_full, q_pop, q_empty;
  item_t q_in, q_out;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ring_count   <= RCNT_W'(20);
      cfg_q.sector_count <= SCNT_W'(60);
      cfg_q.range_min    <= '0;
      cfg_q.range_max    <= CW'(80000);
      cfg_q.first_axis   <= 2'd0;
      cfg_q.second_axis  <= 2'd1;
      cfg_q.height_axis  <= 2'd2;
      cfg_q.height_flip  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_RING_COUNT:   cfg_q.ring_count   <= cfg_data_i[RCNT_W-1:0];
        REG_SECTOR_COUNT: cfg_q.sector_count <= cfg_data_i[SCNT_W-1:0];
        REG_RANGE_MIN:    cfg_q.range_min    <= cfg_data_i;
        REG_RANGE_MAX:    cfg_q.range_max    <= cfg_data_i;
        REG_FIRST_AXIS:   cfg_q.first_axis   <= cfg_data_i[1:0];
        REG_SECOND_AXIS:  cfg_q.second_axis  <= cfg_data_i[1:0];
        REG_HEIGHT_AXIS:  cfg_q.height_axis  <= cfg_data_i[1:0];
        REG_HEIGHT_FLIP:  cfg_q.height_flip  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  assign busy = !front_idle || back_init;

  phgb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .start_i       (start && !busy),
    .action_i      (action_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .coord_z_i     (coord_z_i),
    .read_ring_i   (read_ring_i),
    .read_sector_i (read_sector_i),
    .idle_o        (front_idle),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_item_o      (q_in)
  );

  phgb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (q_out)
  );

  phgb_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_item_i        (q_out),
    .q_pop_o         (q_pop),
    .init_o          (back_init),
    .result_valid_o  (result_valid_o),
    .cell_height_o   (cell_height_o),
    .cell_occupied_o (cell_occupied_o)
  );

`ifndef SYNTHESIS
  // An accepted command always occupies the front end for the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("front end idle after accepting a command");

  // The queue never takes an operation while it is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full))
    else $error("operation pushed into a full queue");

  // A read result is presented for exactly one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held longer than one cycle");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// -----------------------------------------------------------------------------
// Polar height grid binning testbench
// Drives add, read, clear and unused commands into the polar height grid over
// several register settings. A built-in model of the grid predicts each read,
// and a monitor compares every reported cell against the oldest prediction.
// -----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import phgb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One command as presented on the input ports.
  typedef struct {
    logic [1:0]           act;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [RING_W-1:0]    ring;
    logic [SECT_W-1:0]    sect;
  } grid_cmd_t;

  // One expected read answer.
  typedef struct {
    logic [CW-1:0] height;
    logic          occupied;
  } cell_read_t;

  localparam longint HMAX = 524287;
  localparam longint ARC_STEP [CSTEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304};

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           action_i = ACT_READ;
  logic signed [CW-1:0] coord_x_i = '0;
  logic signed [CW-1:0] coord_y_i = '0;
  logic signed [CW-1:0] coord_z_i = '0;
  logic [RING_W-1:0]    read_ring_i = '0;
  logic [SECT_W-1:0]    read_sector_i = '0;
  logic                 result_valid_o;
  logic [CW-1:0]        cell_height_o;
  logic                 cell_occupied_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [2:0]           cfg_index_i = '0;
  logic [CW-1:0]        cfg_data_i = '0;

  // Grid model state and register shadow.
  longint unsigned  shadow_reg [8];
  longint           peak_of [CELLS];
  bit               filled_of [CELLS];
  longint           floor_height;

  grid_cmd_t  cmd_queue [$];
  cell_read_t read_queue [$];
  int         idle_left = 0;
  bit         calm = 1'b0;
  int         mismatches = 0;

  polar_height_grid_binning u_dut (
    .clk_i, .rst_ni, .start, .busy, .action_i, .coord_x_i, .coord_y_i,
    .coord_z_i, .read_ring_i, .read_sector_i, .result_valid_o, .cell_height_o,
    .cell_occupied_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #4 clk_i = ~clk_i;

  // Angle of (a, b) as a 16-bit turn fraction, by CORDIC vectoring.
  function automatic longint turn_of(longint a, longint b);
    longint x, y, z, dx, dy;
    logic [63:0] sum;
    longint base;
    if (b == 0) return (a < 0) ? 32768 : 0;
    if (a == 0) return (b > 0) ? 16384 : 49152;
    base = 0;
    if (a < 0) begin
      a = -a;
      b = -b;
      base = 64'h8000_0000;
    end
    x = a * 1024;
    y = b * 1024;
    z = 0;
    for (int i = 0; i < CSTEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += ARC_STEP[i];
      end else begin
        x -= dx;
        y += dy;
        z -= ARC_STEP[i];
      end
    end
    sum = base + z;
    return longint'(sum[31:16]);
  endfunction

  function automatic longint axis_value(grid_cmd_t c, longint unsigned ax);
    case (ax)
      1: return c.y;
      2: return c.z;
      default: return c.x;
    endcase
  endfunction

  // Applies one accepted command to the grid model.
  function automatic void grid_apply(grid_cmd_t c);
    longint a, b, h, r2, rings, sects, ring, sect, lhs, edge_mm;
    int idx;
    cell_read_t rd;
    case (c.act)
      ACT_CLEAR: begin
        foreach (filled_of[i]) filled_of[i] = 1'b0;
        floor_height = HMAX;
      end
      ACT_READ: begin
        idx = int'(c.ring) * MAX_SECTORS + int'(c.sect);
        rd.height = '0;
        rd.occupied = 1'b0;
        if (filled_of[idx]) begin
          rd.height = CW'(peak_of[idx] - floor_height);
          rd.occupied = 1'b1;
        end
        read_queue = {read_queue, rd};
      end
      ACT_ADD: begin
        a = axis_value(c, shadow_reg[REG_FIRST_AXIS]);
        b = axis_value(c, shadow_reg[REG_SECOND_AXIS]);
        h = axis_value(c, shadow_reg[REG_HEIGHT_AXIS]);
        if (shadow_reg[REG_HEIGHT_FLIP] != 0) h = -h;
        if (h > HMAX) h = HMAX;
        if (h < -HMAX) h = -HMAX;
        r2 = a * a + b * b;
        if (r2 < longint'(shadow_reg[REG_RANGE_MIN] * shadow_reg[REG_RANGE_MIN]) ||
            r2 > longint'(shadow_reg[REG_RANGE_MAX] * shadow_reg[REG_RANGE_MAX]))
          return;
        rings = shadow_reg[REG_RING_COUNT];
        if (rings < 1) rings = 1;
        if (rings > MAX_RINGS) rings = MAX_RINGS;
        sects = shadow_reg[REG_SECTOR_COUNT];
        if (sects < 1) sects = 1;
        if (sects > MAX_SECTORS) sects = MAX_SECTORS;
        ring = 0;
        if (shadow_reg[REG_RANGE_MAX] != 0) begin
          lhs = r2 * rings * rings;
          for (longint k = 1; k < rings; k++) begin
            edge_mm = k * longint'(shadow_reg[REG_RANGE_MAX]);
            if (edge_mm * edge_mm > lhs) break;
            ring = k;
          end
        end
        sect = (turn_of(a, b) * sects) >> 16;
        if (sect > sects - 1) sect = sects - 1;
        idx = int'(ring * MAX_SECTORS + sect);
        if (!filled_of[idx] || h > peak_of[idx]) peak_of[idx] = h;
        filled_of[idx] = 1'b1;
        if (h < floor_height) floor_height = h;
      end
      default: ;
    endcase
  endfunction

  // Command driver: takes the head of the queue, with random idle bursts.
  always @(posedge clk_i) begin
    if (start && !busy) grid_apply(cmd_queue.pop_front());
    if (idle_left > 0) begin
      idle_left--;
      start <= 1'b0;
    end else if (cmd_queue.size() == 0) begin
      start <= 1'b0;
    end else if (!calm && !(start && busy) && $urandom_range(0, 11) == 0) begin
      idle_left = $urandom_range(0, 7);
      start <= 1'b0;
    end else begin
      start <= 1'b1;
      action_i <= cmd_queue[0].act;
      coord_x_i <= cmd_queue[0].x;
      coord_y_i <= cmd_queue[0].y;
      coord_z_i <= cmd_queue[0].z;
      read_ring_i <= cmd_queue[0].ring;
      read_sector_i <= cmd_queue[0].sect;
    end
  end

  // Result monitor: every strobe is matched against the oldest expectation.
  always @(posedge clk_i) begin
    cell_read_t exp_rd;
    if (rst_ni && result_valid_o) begin
      if (read_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected read result: height %0d occupied %0b",
                   cell_height_o, cell_occupied_o);
      end else begin
        exp_rd = read_queue.pop_front();
        if (cell_height_o !== exp_rd.height || cell_occupied_o !== exp_rd.occupied) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Read mismatch: expected height %0d occupied %0b, got %0d %0b",
                     exp_rd.height, exp_rd.occupied, cell_height_o, cell_occupied_o);
        end
      end
    end
  end

  // Writes one register once the channel accepts the transaction.
  task automatic reg_write(logic [2:0] index, longint unsigned value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= CW'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (index)
      REG_RING_COUNT:   shadow_reg[index] = value & 64'h3F;
      REG_SECTOR_COUNT: shadow_reg[index] = value & 64'h7F;
      REG_RANGE_MIN, REG_RANGE_MAX: shadow_reg[index] = value & 64'hFFFFF;
      REG_HEIGHT_FLIP:  shadow_reg[index] = value & 64'h1;
      default:          shadow_reg[index] = value & 64'h3;
    endcase
  endtask

  // Waits until the block has drained every queued command and result.
  task automatic drain();
    while (cmd_queue.size() != 0 || start || read_queue.size() != 0 || busy)
      @(posedge clk_i);
    repeat (2200) @(posedge clk_i);
  endtask

  function automatic void push_cmd(logic [1:0] act, longint x, longint y, longint z,
                                   int ring, int sect);
    grid_cmd_t c;
    c.act = act;
    c.x = CW'(x);
    c.y = CW'(y);
    c.z = CW'(z);
    c.ring = RING_W'(ring);
    c.sect = SECT_W'(sect);
    cmd_queue = {cmd_queue, c};
  endfunction

  // Coordinate mostly inside the active range, sometimes anywhere.
  function automatic longint rand_coord();
    longint span;
    span = longint'(shadow_reg[REG_RANGE_MAX]) * 3 / 4 + 1;
    if (span > HMAX) span = HMAX;
    case ($urandom_range(0, 9))
      0, 1: return longint'($signed(CW'($urandom())));
      2:    return longint'($urandom_range(0, 32)) - 16;
      default: return longint'($urandom_range(0, 2 * span)) - span;
    endcase
  endfunction

  function automatic void random_cmds(int n);
    int pick;
    longint rings, sects;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 199);
      rings = (shadow_reg[REG_RING_COUNT] == 0) ? 1 : shadow_reg[REG_RING_COUNT];
      sects = (shadow_reg[REG_SECTOR_COUNT] == 0) ? 1 : shadow_reg[REG_SECTOR_COUNT];
      if (rings > MAX_RINGS) rings = MAX_RINGS;
      if (sects > MAX_SECTORS) sects = MAX_SECTORS;
      if (pick < 2)
        push_cmd(ACT_CLEAR, rand_coord(), rand_coord(), rand_coord(), 0, 0);
      else if (pick < 6)
        push_cmd(ACT_NOP, rand_coord(), rand_coord(), rand_coord(),
                 $urandom_range(0, 31), $urandom_range(0, 63));
      else if (pick < 120)
        push_cmd(ACT_ADD, rand_coord(), rand_coord(), rand_coord(),
                 $urandom_range(0, 31), $urandom_range(0, 63));
      else if (pick < 180)
        push_cmd(ACT_READ, rand_coord(), rand_coord(), rand_coord(),
                 $urandom_range(0, rings - 1), $urandom_range(0, sects - 1));
      else
        push_cmd(ACT_READ, rand_coord(), rand_coord(), rand_coord(),
                 $urandom_range(0, 31), $urandom_range(0, 63));
    end
  endfunction

  // Register settings of each phase: rings, sectors, min, max, axes, flip.
  longint unsigned phase_set [6][8] = '{
    '{20, 60, 0, 80000, 0, 1, 2, 0},
    '{1, 1, 0, 1, 2, 2, 0, 1},
    '{32, 64, 100, 1048575, 1, 0, 2, 1},
    '{63, 127, 5000, 30000, 3, 2, 1, 0},
    '{0, 0, 0, 0, 0, 1, 2, 1},
    '{7, 13, 70000, 200, 0, 1, 2, 0}
  };

  // Main sequence: reset, directed commands, then random phases.
  initial begin
    shadow_reg = '{20, 60, 0, 80000, 0, 1, 2, 0};
    foreach (filled_of[i]) filled_of[i] = 1'b0;
    foreach (peak_of[i]) peak_of[i] = 0;
    floor_height = HMAX;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, axis-aligned angles, unused action, clear.
    push_cmd(ACT_ADD, 1000, 0, 524287, 0, 0);
    push_cmd(ACT_ADD, -1000, 0, -524288, 0, 0);
    push_cmd(ACT_ADD, 0, 1000, 300, 0, 0);
    push_cmd(ACT_ADD, 0, -1000, -300, 0, 0);
    push_cmd(ACT_ADD, 0, 0, 12, 0, 0);
    push_cmd(ACT_ADD, 40000, 40000, 7, 0, 0);
    push_cmd(ACT_ADD, -524287, 524287, 5, 0, 0);
    push_cmd(ACT_ADD, -30000, -45000, -77, 0, 0);
    push_cmd(ACT_READ, 0, 0, 0, 0, 0);
    push_cmd(ACT_READ, 0, 0, 0, 0, 30);
    push_cmd(ACT_READ, 0, 0, 0, 0, 15);
    push_cmd(ACT_READ, 0, 0, 0, 0, 45);
    push_cmd(ACT_READ, 0, 0, 0, 14, 7);
    push_cmd(ACT_READ, 0, 0, 0, 31, 63);
    push_cmd(ACT_NOP, -1, -1, -1, 31, 63);
    push_cmd(ACT_CLEAR, 0, 0, 0, 0, 0);
    push_cmd(ACT_READ, 0, 0, 0, 0, 0);
    push_cmd(ACT_ADD, 10, 10, -524288, 0, 0);
    push_cmd(ACT_READ, 0, 0, 0, 0, 7);
    drain();

    foreach (phase_set[p]) begin
      for (int r = 0; r < 8; r++) reg_write(3'(r), phase_set[p][r]);
      if (p == 5) calm = 1'b1;
      random_cmds(255);
      drain();
    end

    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/phgb_pkg.sv
rtl/core/phgb_front.sv
rtl/core/phgb_fifo.sv
rtl/core/phgb_back.sv
rtl/core/polar_height_grid_binning.sv
tb/tb_top.sv
